### rtl/atiw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package atiw_pkg;

    // default tree geometry
    localparam int DEF_TREE_SLOTS  = 63;
    localparam int DEF_TREE_HEIGHT = 6;

    // fixed field widths
    localparam int VALUE_W    = 8;
    localparam int SLOT_OUT_W = 6;

    // commands from controller to datapath
    typedef struct packed {
        logic load;     // store the accepted word
        logic start;    // begin a walk at the root
        logic push;     // push current node, go to left child
        logic pop;      // pop a node, visit it, go to right child
        logic finish;   // emit the final result, clear the load
    } atiw_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic present;      // probed slot holds a node and stack has room
        logic stack_empty;
        logic have_pend;    // a visited node waits for its last flag
        logic out_free;     // output register can take a word this cycle
    } atiw_status_t;

endpackage

`default_nettype wire

### rtl/array_tree_inorder_walk_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Inorder walk of a binary tree held level by level (children of slot i at 2i+1, 2i+2).
// Input channel (in_valid / in_stall): one word per slot, starting at slot 0; a
// slot_value of 0 is an empty slot that hides its subtree. last_slot ends the tree.
// Slots past TREE_SLOTS are dropped and every result of that tree shows overflowed.
// Loading takes one word per cycle. After the word with last_slot the block stalls
// its input and walks the tree: a start step, then one stack step at a time (a push
// on the way down, a pop for each visit, each overlapped with one store read), and
// a finish step.
// Output channel (out_valid / out_stall): one word per present node in inorder
// order with its value and slot index; last_result marks the final word. A tree
// with no root gives one word with tree_empty and last_result set.
// The walk holds back one visited node until the next visit or the finish step,
// which loads it into the output register; it is valid the cycle after. A stalled
// output word holds; the walk pauses at its next visit or finish step until the register frees.
// The input is taken again once the final word sits in the output register, even
// while it is stalled.
// Reset empties the load, the stack and the output register; no clearing pass.
module array_tree_inorder_walk_unit #(
    parameter int TREE_SLOTS  = atiw_pkg::DEF_TREE_SLOTS,
    parameter int TREE_HEIGHT = atiw_pkg::DEF_TREE_HEIGHT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [atiw_pkg::VALUE_W-1:0]    slot_value,
    input  wire logic                            last_slot,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic      [atiw_pkg::VALUE_W-1:0]    node_value,
    output logic      [atiw_pkg::SLOT_OUT_W-1:0] node_slot,
    output logic                                 last_result,
    output logic                                 tree_empty,
    output logic                                 overflowed
);

    import atiw_pkg::*;

    atiw_cmd_t    cmd;
    atiw_status_t status;

    // sequencer
    atiw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_slot (last_slot),
        .status    (status),
        .in_stall  (in_stall),
        .cmd       (cmd)
    );

    // store, stack and output register
    atiw_dp #(
        .TREE_SLOTS  (TREE_SLOTS),
        .TREE_HEIGHT (TREE_HEIGHT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .slot_value  (slot_value),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .node_value  (node_value),
        .node_slot   (node_slot),
        .last_result (last_result),
        .tree_empty  (tree_empty),
        .overflowed  (overflowed)
    );

endmodule

`default_nettype wire

### rtl/atiw_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module atiw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/atiw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module atiw_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic                   last_slot,
    input  wire atiw_pkg::atiw_status_t status,
    output logic                        in_stall,
    output atiw_pkg::atiw_cmd_t         cmd
);

    import atiw_pkg::*;

    localparam logic [1:0] S_LOAD  = 2'd0;
    localparam logic [1:0] S_START = 2'd1;
    localparam logic [1:0] S_PROBE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            S_LOAD:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (last_slot)
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                cmd.start  = 1'b1;
                state_next = S_PROBE;
            end
            S_PROBE:
            begin
                if (status.present)
                begin
                    cmd.push = 1'b1;
                end
                else if (!status.stack_empty)
                begin
                    // a pop hands the pending node to the output register
                    if (!status.have_pend || status.out_free)
                    begin
                        cmd.pop = 1'b1;
                    end
                end
                else if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### rtl/atiw_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module atiw_dp #(
    parameter int TREE_SLOTS  = atiw_pkg::DEF_TREE_SLOTS,
    parameter int TREE_HEIGHT = atiw_pkg::DEF_TREE_HEIGHT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic [atiw_pkg::VALUE_W-1:0]        slot_value,
    input  wire atiw_pkg::atiw_cmd_t                 cmd,
    output atiw_pkg::atiw_status_t                   status,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic      [atiw_pkg::VALUE_W-1:0]        node_value,
    output logic      [atiw_pkg::SLOT_OUT_W-1:0]     node_slot,
    output logic                                     last_result,
    output logic                                     tree_empty,
    output logic                                     overflowed
);

    import atiw_pkg::*;

    localparam int SLOT_W = (TREE_SLOTS > 1) ? $clog2(TREE_SLOTS) : 1;
    localparam int CNT_W  = $clog2(TREE_SLOTS + 1);
    localparam int IDX_W  = $clog2(2 * TREE_SLOTS + 1);
    localparam int TOP_W  = $clog2(TREE_HEIGHT + 1);
    localparam int STK_AW = (TREE_HEIGHT > 1) ? $clog2(TREE_HEIGHT) : 1;

    // load state
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic             store_full;

    // walk state
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    logic [TOP_W-1:0]   top_reg;
    logic [TOP_W-1:0]   top_next;
    logic [SLOT_W-1:0]  stk_idx_reg [TREE_HEIGHT];
    logic [VALUE_W-1:0] stk_val_reg [TREE_HEIGHT];
    logic [SLOT_W-1:0]  pop_idx;
    logic [VALUE_W-1:0] pop_val;
    logic [STK_AW-1:0]  push_ptr;
    logic [STK_AW-1:0]  pop_ptr;

    // node waiting for the next visit, which tells whether it is last
    logic               pend_reg;
    logic               pend_next;
    logic [SLOT_W-1:0]  pend_idx_reg;
    logic [VALUE_W-1:0] pend_val_reg;

    // output register
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [VALUE_W-1:0]    out_val_reg;
    logic [SLOT_OUT_W-1:0] out_slot_reg;
    logic                  out_last_reg;
    logic                  out_empty_reg;
    logic                  out_ovf_reg;
    logic                  out_free;

    // slot store
    logic [VALUE_W-1:0] rd_val;
    logic [SLOT_W-1:0]  raddr;
    logic [SLOT_W-1:0]  waddr;

    assign store_full = (count_reg == CNT_W'(TREE_SLOTS));
    assign waddr      = SLOT_W'(count_reg);
    assign raddr      = SLOT_W'(idx_next);

    atiw_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TREE_SLOTS)
    ) u_store (
        .clk   (clk),
        .we    (cmd.load && !store_full),
        .waddr (waddr),
        .wdata (slot_value),
        .raddr (raddr),
        .rdata (rd_val)
    );

    // stack pointers and top entry
    assign push_ptr = STK_AW'(top_reg);
    assign pop_ptr  = STK_AW'(top_reg - TOP_W'(1));
    assign pop_idx  = stk_idx_reg[pop_ptr];
    assign pop_val  = stk_val_reg[pop_ptr];

    // status toward the controller
    assign out_free           = !out_valid_reg || !out_stall;
    assign status.present     = (idx_reg < IDX_W'(count_reg)) && (rd_val != '0)
                                && (top_reg < TOP_W'(TREE_HEIGHT));
    assign status.stack_empty = (top_reg == '0);
    assign status.have_pend   = pend_reg;
    assign status.out_free    = out_free;

    // load counter and drop flag
    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (cmd.finish)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
        else if (cmd.load)
        begin
            if (store_full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    // walk index, stack depth and pending flag
    always_comb
    begin
        idx_next  = idx_reg;
        top_next  = top_reg;
        pend_next = pend_reg;
        if (cmd.start)
        begin
            idx_next  = '0;
            top_next  = '0;
            pend_next = 1'b0;
        end
        else if (cmd.push)
        begin
            idx_next = (idx_reg << 1) | IDX_W'(1);
            top_next = top_reg + TOP_W'(1);
        end
        else if (cmd.pop)
        begin
            idx_next  = (IDX_W'(pop_idx) << 1) + IDX_W'(2);
            top_next  = top_reg - TOP_W'(1);
            pend_next = 1'b1;
        end
        else if (cmd.finish)
        begin
            pend_next = 1'b0;
        end
    end

    // output valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if ((cmd.pop && pend_reg) || cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            top_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            top_reg       <= top_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers: index, stack, pending node, output word
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.push)
        begin
            stk_idx_reg[push_ptr] <= SLOT_W'(idx_reg);
            stk_val_reg[push_ptr] <= rd_val;
        end
        if (cmd.pop)
        begin
            pend_idx_reg <= pop_idx;
            pend_val_reg <= pop_val;
        end
        if (cmd.pop && pend_reg)
        begin
            out_val_reg   <= pend_val_reg;
            out_slot_reg  <= SLOT_OUT_W'(pend_idx_reg);
            out_last_reg  <= 1'b0;
            out_empty_reg <= 1'b0;
            out_ovf_reg   <= ovf_reg;
        end
        else if (cmd.finish)
        begin
            out_last_reg <= 1'b1;
            out_ovf_reg  <= ovf_reg;
            if (pend_reg)
            begin
                out_val_reg   <= pend_val_reg;
                out_slot_reg  <= SLOT_OUT_W'(pend_idx_reg);
                out_empty_reg <= 1'b0;
            end
            else
            begin
                out_val_reg   <= '0;
                out_slot_reg  <= '0;
                out_empty_reg <= 1'b1;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign node_value  = out_val_reg;
    assign node_slot   = out_slot_reg;
    assign last_result = out_last_reg;
    assign tree_empty  = out_empty_reg;
    assign overflowed  = out_ovf_reg;

endmodule

`default_nettype wire
